### sv/ecsm_pkg.sv
// ----------------------------------------------------------------------------
// ecsm_pkg: shared types and microcode for the EC scalar multiplier
// Field operation codes, register ids, the sequencer microcode store and
// defaults for the top level's parameters.
// ----------------------------------------------------------------------------
package ecsm_pkg;

	localparam int FIELD_BITS_DEF  = 31;
	localparam int SCALAR_BITS_DEF = 32;
	localparam longint unsigned MODULUS_RST = 64'd2147483647;
	localparam int PC_W = 6;

	// configuration register indexes
	localparam logic [1:0] CFG_MODULUS = 2'd0;
	localparam logic [1:0] CFG_CURVE_A = 2'd1;
	localparam logic [1:0] CFG_CURVE_B = 2'd2;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_MOD,
		OP_INV,
		OP_RET
	} alu_op_t;

	typedef enum logic [3:0] {
		R_ZERO,
		R_IX,
		R_IY,
		R_IA,
		R_IB,
		R_I3,
		R_X,
		R_Y,
		R_CA,
		R_CB,
		R_K3,
		R_AX,
		R_AY,
		R_T0,
		R_T1,
		R_S
	} reg_id_t;

	typedef struct packed {
		alu_op_t op;
		reg_id_t dst;
		reg_id_t sa;
		reg_id_t sb;
	} uop_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	// program entry points
	localparam logic [PC_W-1:0] ENT_SETUP = 6'd0;
	localparam logic [PC_W-1:0] ENT_DBL   = 6'd12;
	localparam logic [PC_W-1:0] ENT_ADD   = 6'd26;

	function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			// reduce operands, then evaluate both sides of the curve equation
			6'd0:  u = '{OP_MOD, R_X,  R_IX, R_ZERO};
			6'd1:  u = '{OP_MOD, R_Y,  R_IY, R_ZERO};
			6'd2:  u = '{OP_MOD, R_CA, R_IA, R_ZERO};
			6'd3:  u = '{OP_MOD, R_CB, R_IB, R_ZERO};
			6'd4:  u = '{OP_MOD, R_K3, R_I3, R_ZERO};
			6'd5:  u = '{OP_MUL, R_T0, R_Y,  R_Y};
			6'd6:  u = '{OP_MUL, R_T1, R_X,  R_X};
			6'd7:  u = '{OP_MUL, R_T1, R_X,  R_T1};
			6'd8:  u = '{OP_MUL, R_S,  R_CA, R_X};
			6'd9:  u = '{OP_ADD, R_T1, R_T1, R_S};
			6'd10: u = '{OP_ADD, R_T1, R_T1, R_CB};
			6'd11: u = '{OP_RET, R_ZERO, R_ZERO, R_ZERO};
			// double the accumulator
			6'd12: u = '{OP_MUL, R_T0, R_AX, R_AX};
			6'd13: u = '{OP_MUL, R_T0, R_T0, R_K3};
			6'd14: u = '{OP_ADD, R_T0, R_T0, R_CA};
			6'd15: u = '{OP_ADD, R_T1, R_AY, R_AY};
			6'd16: u = '{OP_INV, R_T1, R_T1, R_ZERO};
			6'd17: u = '{OP_MUL, R_S,  R_T0, R_T1};
			6'd18: u = '{OP_MUL, R_T0, R_S,  R_S};
			6'd19: u = '{OP_SUB, R_T0, R_T0, R_AX};
			6'd20: u = '{OP_SUB, R_T0, R_T0, R_AX};
			6'd21: u = '{OP_SUB, R_T1, R_AX, R_T0};
			6'd22: u = '{OP_MUL, R_T1, R_T1, R_S};
			6'd23: u = '{OP_SUB, R_AY, R_T1, R_AY};
			6'd24: u = '{OP_ADD, R_AX, R_T0, R_ZERO};
			6'd25: u = '{OP_RET, R_ZERO, R_ZERO, R_ZERO};
			// add the base point to the accumulator
			6'd26: u = '{OP_SUB, R_T0, R_AY, R_Y};
			6'd27: u = '{OP_SUB, R_T1, R_AX, R_X};
			6'd28: u = '{OP_INV, R_T1, R_T1, R_ZERO};
			6'd29: u = '{OP_MUL, R_S,  R_T0, R_T1};
			6'd30: u = '{OP_MUL, R_T0, R_S,  R_S};
			6'd31: u = '{OP_SUB, R_T0, R_T0, R_X};
			6'd32: u = '{OP_SUB, R_T0, R_T0, R_AX};
			6'd33: u = '{OP_SUB, R_T1, R_X,  R_T0};
			6'd34: u = '{OP_MUL, R_T1, R_T1, R_S};
			6'd35: u = '{OP_SUB, R_AY, R_T1, R_Y};
			6'd36: u = '{OP_ADD, R_AX, R_T0, R_ZERO};
			default: u = '{OP_RET, R_ZERO, R_ZERO, R_ZERO};
		endcase
		return u;
	endfunction

endpackage

### sv/ecsm_alu.sv
// ----------------------------------------------------------------------------
// ecsm_alu: bit-serial GF(p) arithmetic unit
// Add and subtract registered straight from idle; multiply by shift-and-add one bit per cycle;
// reduction by restoring division one bit per cycle; inversion by extended
// Euclid built from the serial divider and multiplier.
// ----------------------------------------------------------------------------
module ecsm_alu import ecsm_pkg::*; #(
	parameter int FIELD_BITS = FIELD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  alu_req_t              req,
	input  logic [FIELD_BITS-1:0] opa,
	input  logic [FIELD_BITS-1:0] opb,
	input  logic [FIELD_BITS-1:0] fm,
	output logic                  done,
	output logic [FIELD_BITS-1:0] res
);

	localparam int CW = $clog2(FIELD_BITS);

	typedef enum logic [5:0] {
		AS_IDLE = 6'b000001,
		AS_MUL  = 6'b000010,
		AS_DIV  = 6'b000100,
		AS_ICHK = 6'b001000,
		AS_IDIV = 6'b010000,
		AS_IMUL = 6'b100000
	} alu_st_t;

	function automatic logic [FIELD_BITS-1:0] madd(
		input logic [FIELD_BITS-1:0] a,
		input logic [FIELD_BITS-1:0] b,
		input logic [FIELD_BITS-1:0] m
	);
		logic [FIELD_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, m}) s = s - {1'b0, m};
		return s[FIELD_BITS-1:0];
	endfunction

	function automatic logic [FIELD_BITS-1:0] msub(
		input logic [FIELD_BITS-1:0] a,
		input logic [FIELD_BITS-1:0] b,
		input logic [FIELD_BITS-1:0] m
	);
		logic [FIELD_BITS:0] d;
		if (a >= b) d = {1'b0, a} - {1'b0, b};
		else d = {1'b0, a} + {1'b0, m} - {1'b0, b};
		return d[FIELD_BITS-1:0];
	endfunction

	alu_st_t               st_q;
	logic                  done_q;
	logic [FIELD_BITS-1:0] res_q;
	logic [FIELD_BITS-1:0] mr_q, ma_q, mb_q;
	logic [FIELD_BITS-1:0] rem_q, dv_q, quo_q;
	logic [CW-1:0]         cnt_q;
	logic [FIELD_BITS-1:0] r0_q, r1_q, s0_q, s1_q;

	logic [FIELD_BITS-1:0] divisor;
	logic [FIELD_BITS:0]   trial, trial_sub;
	logic                  qbit;
	logic [FIELD_BITS-1:0] rem_nx, quo_nx;
	logic [FIELD_BITS-1:0] mul_r, ma_dbl;

	always_comb begin
		divisor   = (st_q == AS_IDIV) ? r1_q : fm;
		trial     = {rem_q, dv_q[FIELD_BITS-1]};
		trial_sub = trial - {1'b0, divisor};
		qbit      = (trial >= {1'b0, divisor});
		rem_nx    = qbit ? trial_sub[FIELD_BITS-1:0] : trial[FIELD_BITS-1:0];
		quo_nx    = {quo_q[FIELD_BITS-2:0], qbit};
		mul_r     = mb_q[0] ? madd(mr_q, ma_q, fm) : mr_q;
		ma_dbl    = madd(ma_q, ma_q, fm);
	end

	// pulse done in the same cycle as the result lands in res_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			case (st_q)
				AS_IDLE: done_q <= req.start && (req.op != OP_MUL) &&
					(req.op != OP_MOD) && (req.op != OP_INV);
				AS_MUL:  done_q <= (mb_q == '0);
				AS_DIV:  done_q <= (cnt_q == '0);
				AS_ICHK: done_q <= (r1_q == '0);
				default: done_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= AS_IDLE;
		end else begin
			case (st_q)
				AS_IDLE: begin
					if (req.start) begin
						case (req.op)
							OP_ADD: begin
								res_q  <= madd(opa, opb, fm);
							end
							OP_SUB: begin
								res_q  <= msub(opa, opb, fm);
							end
							OP_MUL: begin
								mr_q <= '0;
								ma_q <= opa;
								mb_q <= opb;
								st_q <= AS_MUL;
							end
							OP_MOD: begin
								rem_q <= '0;
								dv_q  <= opa;
								cnt_q <= CW'(FIELD_BITS - 1);
								st_q  <= AS_DIV;
							end
							OP_INV: begin
								r0_q <= opa;
								r1_q <= fm;
								s0_q <= {{(FIELD_BITS-1){1'b0}}, (fm != FIELD_BITS'(1))};
								s1_q <= '0;
								st_q <= AS_ICHK;
							end
							default: ;
						endcase
					end
				end
				AS_MUL: begin
					if (mb_q == '0) begin
						res_q  <= mr_q;
						st_q   <= AS_IDLE;
					end else begin
						mr_q <= mul_r;
						ma_q <= ma_dbl;
						mb_q <= mb_q >> 1;
					end
				end
				AS_DIV: begin
					rem_q <= rem_nx;
					dv_q  <= dv_q << 1;
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) begin
						res_q  <= rem_nx;
						st_q   <= AS_IDLE;
					end
				end
				AS_ICHK: begin
					if (r1_q == '0) begin
						res_q  <= s0_q;
						st_q   <= AS_IDLE;
					end else begin
						rem_q <= '0;
						dv_q  <= r0_q;
						cnt_q <= CW'(FIELD_BITS - 1);
						st_q  <= AS_IDIV;
					end
				end
				AS_IDIV: begin
					rem_q <= rem_nx;
					dv_q  <= dv_q << 1;
					quo_q <= quo_nx;
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) begin
						// rotate remainders, then form q * s1
						r0_q <= r1_q;
						r1_q <= rem_nx;
						ma_q <= quo_nx;
						mb_q <= s1_q;
						mr_q <= '0;
						st_q <= AS_IMUL;
					end
				end
				AS_IMUL: begin
					if (mb_q == '0) begin
						s1_q <= msub(s0_q, mr_q, fm);
						s0_q <= s1_q;
						st_q <= AS_ICHK;
					end else begin
						mr_q <= mul_r;
						ma_q <= ma_dbl;
						mb_q <= mb_q >> 1;
					end
				end
				default: st_q <= AS_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

### sv/ec_scalar_multiply_prime_field.sv
// ----------------------------------------------------------------------------
// ec_scalar_multiply_prime_field: affine double-and-add over GF(p)
// Checks the input point against the curve, then forms scalar * point.
// ----------------------------------------------------------------------------
// One word in, one word out. The block first checks y^2 = x^3 + a*x + b and,
// for a point on the curve, scans the scalar from its top bit with affine
// doubling and addition; (0,0) stands for the point at infinity. All field
// arithmetic runs through one bit-serial unit, and an inversion runs
// extended Euclid with one serial division and one serial multiply per round
// (up to about 1.44*FIELD_BITS rounds). A doubling costs one inversion and
// five multiplies, an addition one inversion and three. A point off the
// curve returns without the scan. The next word is taken once the previous
// result has moved to the output register.
// ----------------------------------------------------------------------------
module ec_scalar_multiply_prime_field import ecsm_pkg::*; #(
	parameter int FIELD_BITS  = FIELD_BITS_DEF,
	parameter int SCALAR_BITS = SCALAR_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [FIELD_BITS-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [FIELD_BITS-1:0]  point_x,
	input  logic [FIELD_BITS-1:0]  point_y,
	input  logic [SCALAR_BITS-1:0] scalar,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   on_curve,
	output logic                   at_infinity,
	output logic [FIELD_BITS-1:0]  result_x,
	output logic [FIELD_BITS-1:0]  result_y
);

	localparam int IW = $clog2(SCALAR_BITS);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_RUN    = 7'b0000010,
		ST_WAIT   = 7'b0000100,
		ST_STEP   = 7'b0001000,
		ST_ADDCHK = 7'b0010000,
		ST_NEXT   = 7'b0100000,
		ST_OUT    = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		PH_SETUP,
		PH_DBL,
		PH_DBLADD,
		PH_ADD
	} phase_t;

	state_t                 state_q;
	phase_t                 phase_q;
	logic [PC_W-1:0]        pc_q;
	logic [IW-1:0]          idx_q;
	logic                   started_q, oncurve_q;
	logic [FIELD_BITS-1:0]  modulus_q, curve_a_q, curve_b_q;
	logic [FIELD_BITS-1:0]  in_x_q, in_y_q;
	logic [SCALAR_BITS-1:0] scalar_q;
	logic [FIELD_BITS-1:0]  x_q, y_q, ca_q, cb_q, k3_q, ax_q, ay_q, t0_q, t1_q, s_q;
	logic                   out_valid_q, on_curve_q, inf_q;
	logic [FIELD_BITS-1:0]  rx_q, ry_q;

	uop_t                  uop;
	alu_req_t              alu_req;
	logic                  alu_done;
	logic [FIELD_BITS-1:0] alu_res, opa, opb, fm;
	logic                  acc_inf, base_inf, cur_bit;

	function automatic logic [FIELD_BITS-1:0] pick(
		input reg_id_t               id,
		input logic [FIELD_BITS-1:0] ix, iy, ia, ib,
		input logic [FIELD_BITS-1:0] x, y, ca, cb, k3,
		input logic [FIELD_BITS-1:0] ax, ay, t0, t1, s
	);
		logic [FIELD_BITS-1:0] v;
		case (id)
			R_ZERO: v = '0;
			R_IX:   v = ix;
			R_IY:   v = iy;
			R_IA:   v = ia;
			R_IB:   v = ib;
			R_I3:   v = FIELD_BITS'(3);
			R_X:    v = x;
			R_Y:    v = y;
			R_CA:   v = ca;
			R_CB:   v = cb;
			R_K3:   v = k3;
			R_AX:   v = ax;
			R_AY:   v = ay;
			R_T0:   v = t0;
			R_T1:   v = t1;
			R_S:    v = s;
			default: v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		uop      = uop_rom(pc_q);
		fm       = (modulus_q == '0) ? FIELD_BITS'(1) : modulus_q;
		opa      = pick(uop.sa, in_x_q, in_y_q, curve_a_q, curve_b_q, x_q, y_q, ca_q,
			cb_q, k3_q, ax_q, ay_q, t0_q, t1_q, s_q);
		opb      = pick(uop.sb, in_x_q, in_y_q, curve_a_q, curve_b_q, x_q, y_q, ca_q,
			cb_q, k3_q, ax_q, ay_q, t0_q, t1_q, s_q);
		alu_req.start = (state_q == ST_RUN) && (uop.op != OP_RET);
		alu_req.op    = uop.op;
		acc_inf  = (ax_q == '0) && (ay_q == '0);
		base_inf = (x_q == '0) && (y_q == '0);
		cur_bit  = scalar_q[idx_q];
	end

	ecsm_alu #(
		.FIELD_BITS(FIELD_BITS)
	) u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.opa   (opa),
		.opb   (opb),
		.fm    (fm),
		.done  (alu_done),
		.res   (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_SETUP;
			pc_q        <= '0;
			idx_q       <= '0;
			started_q   <= 1'b0;
			oncurve_q   <= 1'b0;
			modulus_q   <= FIELD_BITS'(MODULUS_RST);
			curve_a_q   <= '0;
			curve_b_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODULUS: modulus_q <= cfg_data;
					CFG_CURVE_A: curve_a_q <= cfg_data;
					CFG_CURVE_B: curve_b_q <= cfg_data;
					default: ;
				endcase
			end

			// drop the output word once taken, unless a new one loads now
			if (out_valid_q && !out_stall && state_q != ST_OUT) out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						in_x_q   <= point_x;
						in_y_q   <= point_y;
						scalar_q <= scalar;
						pc_q     <= ENT_SETUP;
						phase_q  <= PH_SETUP;
						state_q  <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (uop.op == OP_RET) begin
						case (phase_q)
							PH_SETUP: begin
								ax_q      <= '0;
								ay_q      <= '0;
								started_q <= 1'b0;
								idx_q     <= IW'(SCALAR_BITS - 1);
								oncurve_q <= (t0_q == t1_q);
								state_q   <= (t0_q == t1_q) ? ST_STEP : ST_OUT;
							end
							PH_DBL:  state_q <= ST_ADDCHK;
							default: state_q <= ST_NEXT;
						endcase
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (alu_done) begin
						case (uop.dst)
							R_X:  x_q  <= alu_res;
							R_Y:  y_q  <= alu_res;
							R_CA: ca_q <= alu_res;
							R_CB: cb_q <= alu_res;
							R_K3: k3_q <= alu_res;
							R_AX: ax_q <= alu_res;
							R_AY: ay_q <= alu_res;
							R_T0: t0_q <= alu_res;
							R_T1: t1_q <= alu_res;
							R_S:  s_q  <= alu_res;
							default: ;
						endcase
						pc_q    <= pc_q + PC_W'(1);
						state_q <= ST_RUN;
					end
				end
				ST_STEP: begin
					if (!started_q) begin
						// leading zeros leave the accumulator at infinity
						if (cur_bit) begin
							ax_q      <= x_q;
							ay_q      <= y_q;
							started_q <= 1'b1;
						end
						state_q <= ST_NEXT;
					end else if (ay_q == '0) begin
						ax_q    <= '0;
						ay_q    <= '0;
						state_q <= ST_ADDCHK;
					end else begin
						pc_q    <= ENT_DBL;
						phase_q <= PH_DBL;
						state_q <= ST_RUN;
					end
				end
				ST_ADDCHK: begin
					if (!cur_bit || base_inf) begin
						state_q <= ST_NEXT;
					end else if (acc_inf) begin
						ax_q    <= x_q;
						ay_q    <= y_q;
						state_q <= ST_NEXT;
					end else if (ax_q == x_q && ay_q == y_q) begin
						// equal points: double instead of add
						if (ay_q == '0) begin
							ax_q    <= '0;
							ay_q    <= '0;
							state_q <= ST_NEXT;
						end else begin
							pc_q    <= ENT_DBL;
							phase_q <= PH_DBLADD;
							state_q <= ST_RUN;
						end
					end else if (ax_q == x_q) begin
						// P + (-P)
						ax_q    <= '0;
						ay_q    <= '0;
						state_q <= ST_NEXT;
					end else begin
						pc_q    <= ENT_ADD;
						phase_q <= PH_ADD;
						state_q <= ST_RUN;
					end
				end
				ST_NEXT: begin
					if (idx_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						idx_q   <= idx_q - IW'(1);
						state_q <= ST_STEP;
					end
				end
				ST_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						on_curve_q  <= oncurve_q;
						inf_q       <= oncurve_q & acc_inf;
						rx_q        <= ax_q;
						ry_q        <= ay_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign on_curve    = on_curve_q;
	assign at_infinity = inf_q;
	assign result_x    = rx_q;
	assign result_y    = ry_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> state_q == ST_WAIT)
		else $error("field unit finished outside a wait step");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_RUN && pc_q == ENT_SETUP)
		else $error("accepted word did not start the setup program");

	a_off_curve_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !on_curve_q |-> !inf_q && rx_q == '0 && ry_q == '0)
		else $error("off-curve result carries nonzero fields");

	a_inf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && inf_q |-> rx_q == '0 && ry_q == '0)
		else $error("infinity result with nonzero coordinates");

endmodule

### verif/ecsm_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ecsm_result_checker: scoreboard for the EC scalar multiplier
// Tracks register writes, predicts the curve check and the product n*P for
// every accepted word, and compares each output word in order.
// ----------------------------------------------------------------------------
module ecsm_result_checker import ecsm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [30:0] point_x,
	input  logic [30:0] point_y,
	input  logic [31:0] scalar,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        on_curve,
	input  logic        at_infinity,
	input  logic [30:0] result_x,
	input  logic [30:0] result_y,
	output int          outstanding,
	output int          failures
);

	typedef struct packed {
		logic        on_curve;
		logic        at_inf;
		logic [30:0] x;
		logic [30:0] y;
	} product_t;

	product_t expected_products[$];
	logic [30:0] modulus_q, curve_a_q, curve_b_q;

	function automatic longint unsigned fadd(input longint unsigned a, b, m);
		return (a + b) % m;
	endfunction

	function automatic longint unsigned fsub(input longint unsigned a, b, m);
		return (a >= b) ? a - b : a + (m - b);
	endfunction

	function automatic longint unsigned fmul(input longint unsigned a, b, m);
		return (a * b) % m;
	endfunction

	// Bezout coefficient of v modulo m; zero maps to zero
	function automatic longint unsigned finv(input longint unsigned v, m);
		longint unsigned r0, r1, s0, s1, q, rt, st;
		r0 = v; r1 = m; s0 = 1 % m; s1 = 0;
		while (r1 != 0) begin
			q  = r0 / r1;
			rt = r0 - q * r1;
			st = fsub(s0, fmul(q % m, s1, m), m);
			r0 = r1; r1 = rt;
			s0 = s1; s1 = st;
		end
		return s0;
	endfunction

	function automatic void point_double(input longint unsigned m, a,
			inout longint unsigned x, y);
		longint unsigned num, s, nx;
		if (y == 0) begin
			x = 0; y = 0;
			return;
		end
		num = fadd(fmul(fmul(x, x, m), 3 % m, m), a, m);
		s   = fmul(num, finv(fadd(y, y, m), m), m);
		nx  = fsub(fsub(fmul(s, s, m), x, m), x, m);
		y   = fsub(fmul(fsub(x, nx, m), s, m), y, m);
		x   = nx;
	endfunction

	// acc = base + acc
	function automatic void point_add(input longint unsigned m, a, bx, by,
			inout longint unsigned x, y);
		longint unsigned s, nx;
		if (bx == 0 && by == 0) return;
		if (x == 0 && y == 0) begin
			x = bx; y = by;
			return;
		end
		if (bx == x && by == y) begin
			point_double(m, a, x, y);
			return;
		end
		if (bx == x) begin
			x = 0; y = 0;
			return;
		end
		s  = fmul(fsub(y, by, m), finv(fsub(x, bx, m), m), m);
		nx = fsub(fsub(fmul(s, s, m), bx, m), x, m);
		y  = fsub(fmul(fsub(bx, nx, m), s, m), by, m);
		x  = nx;
	endfunction

	// left-to-right double-and-add; m is the effective modulus
	function automatic logic [61:0] scale_point(input longint unsigned m, a, x, y,
			input logic [31:0] n);
		longint unsigned ax, ay, ca;
		logic started;
		ax = 0; ay = 0; started = 0;
		ca = a % m;
		for (int i = 31; i >= 0; i--) begin
			if (!started) begin
				if (n[i]) begin
					ax = x; ay = y; started = 1;
				end
			end else begin
				point_double(m, ca, ax, ay);
				if (n[i]) point_add(m, ca, x, y, ax, ay);
			end
		end
		return {ax[30:0], ay[30:0]};
	endfunction

	function automatic product_t predict_product(input logic [30:0] x, y,
			input logic [31:0] n);
		longint unsigned m, ca, bx, by, lhs, rhs;
		logic [61:0] pr;
		product_t r;
		m   = (modulus_q == 0) ? 1 : modulus_q;
		ca  = curve_a_q % m;
		bx  = x % m;
		by  = y % m;
		lhs = fmul(by, by, m);
		rhs = fadd(fadd(fmul(bx, fmul(bx, bx, m), m), fmul(ca, bx, m), m),
			curve_b_q % m, m);
		r = '0;
		if (lhs != rhs) return r;
		pr = scale_point(m, ca, bx, by, n);
		r.on_curve = 1;
		r.at_inf   = (pr == 0);
		r.x        = pr[61:31];
		r.y        = pr[30:0];
		return r;
	endfunction

	assign outstanding = expected_products.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= 31'(MODULUS_RST);
			curve_a_q <= '0;
			curve_b_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODULUS: modulus_q <= cfg_data;
				CFG_CURVE_A: curve_a_q <= cfg_data;
				CFG_CURVE_B: curve_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	initial failures = 0;

	always @(posedge clk) begin
		product_t want;
		if (arst_n && in_valid && !in_stall)
			expected_products.push_back(predict_product(point_x, point_y, scalar));
		if (arst_n && out_valid && !out_stall) begin
			if (expected_products.size() == 0) begin
				$display("%t: unexpected word on_curve=%0d inf=%0d x=%0d y=%0d", $time,
					on_curve, at_infinity, result_x, result_y);
				failures <= failures + 1;
			end else begin
				want = expected_products.pop_front();
				if (want.on_curve !== on_curve || want.at_inf !== at_infinity ||
						want.x !== result_x || want.y !== result_y) begin
					$display("%t: mismatch expected on_curve=%0d inf=%0d x=%0d y=%0d", $time,
						want.on_curve, want.at_inf, want.x, want.y);
					$display("%t:          actual   on_curve=%0d inf=%0d x=%0d y=%0d", $time,
						on_curve, at_infinity, result_x, result_y);
					failures <= failures + 1;
				end
			end
		end
	end

endmodule

### verif/ec_scalar_multiply_prime_field_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ec_scalar_multiply_prime_field_tb: stimulus and verdict for the multiplier
// Runs several curve settings; per setting a base point is picked and b is
// derived so it lies on the curve, then multiples, negations, off-curve
// points and infinity are fed, mostly with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module ec_scalar_multiply_prime_field_tb;
	import ecsm_pkg::*;

	localparam longint LIMIT = 200_000_000;

	logic        clk, arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [30:0] cfg_data;
	logic        in_valid, in_stall;
	logic [30:0] point_x, point_y;
	logic [31:0] scalar;
	logic        out_valid, out_stall;
	logic        on_curve, at_infinity;
	logic [30:0] result_x, result_y;
	int          outstanding, failures;
	logic        quiet;
	longint      cycles;

	longint unsigned fm, cur_a, base_x, base_y;

	ec_scalar_multiply_prime_field uut (.*);

	ecsm_result_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// back-pressure on the output channel
	always @(posedge clk)
		out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 21);

	task automatic write_reg(input logic [1:0] idx, input longint unsigned val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[30:0];
		@(posedge clk);
	endtask

	task automatic drain();
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic send_word(input longint unsigned x, y, input logic [31:0] n);
		if (!quiet && $urandom_range(0, 99) < 21) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_x  <= x[30:0];
		point_y  <= y[30:0];
		scalar   <= n;
		do @(posedge clk); while (in_stall);
	endtask

	// pick a base point, derive b so it sits on the curve, load registers
	task automatic set_curve(input longint unsigned modv, input logic y_zero);
		longint unsigned b;
		fm     = (modv == 0) ? 1 : modv;
		cur_a  = $urandom_range(0, 2147483646);
		base_x = $urandom_range(0, 32'(fm - 1));
		base_y = y_zero ? 0 : $urandom_range(0, 32'(fm - 1));
		b = chk.fsub(chk.fmul(base_y, base_y, fm), chk.fadd(chk.fmul(base_x,
			chk.fmul(base_x, base_x, fm), fm), chk.fmul(cur_a % fm, base_x, fm), fm), fm);
		if (modv == 0) b = $urandom_range(0, 2147483646);
		write_reg(CFG_MODULUS, modv);
		write_reg(CFG_CURVE_A, cur_a);
		write_reg(CFG_CURVE_B, b);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_scalar();
		int r;
		r = $urandom_range(0, 99);
		if (r < 88) return $urandom_range(0, 63);
		if (r < 95) return $urandom;
		return (r & 1) ? 32'hFFFF_FFFF : 32'h0;
	endfunction

	task automatic random_words(input int count);
		logic [61:0] g;
		longint unsigned px, py;
		int kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 99);
			g  = chk.scale_point(fm, cur_a, base_x, base_y, $urandom_range(1, 65535));
			px = g[61:31];
			py = g[30:0];
			if (kind >= 70 && kind < 80) begin
				py = (py == 0) ? 0 : fm - py;
			end else if (kind >= 80 && kind < 90) begin
				px = $urandom & 32'h7FFF_FFFF;
				py = $urandom & 32'h7FFF_FFFF;
			end else if (kind >= 90 && kind < 95) begin
				px = 0; py = 0;
			end else if (kind >= 95) begin
				// unreduced coordinates
				if (px + fm <= 64'h7FFF_FFFF) px = px + fm;
				if (py + fm <= 64'h7FFF_FFFF) py = py + fm;
			end
			send_word(px, py, pick_scalar());
		end
		in_valid <= 1'b0;
		@(posedge clk);
		drain();
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_MODULUS;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		point_x   <= '0;
		point_y   <= '0;
		scalar    <= '0;
		out_stall <= 1'b0;
		quiet     = 1'b0;
		repeat (12) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: largest 31-bit prime, edge scalars and points
		set_curve(2147483647, 1'b0);
		send_word(base_x, base_y, 32'd0);
		send_word(base_x, base_y, 32'd1);
		send_word(base_x, base_y, 32'd2);
		send_word(base_x, base_y, 32'd3);
		send_word(base_x, base_y, 32'hFFFF_FFFF);
		send_word(base_x, base_y, 32'h8000_0000);
		send_word(base_x, (base_y == 0) ? 0 : fm - base_y, 32'd5);
		send_word(0, 0, 32'd7);
		send_word(base_x, (base_y + 1) % fm, 32'd9);
		send_word(2147483646, 2147483646, 32'd3);
		send_word(0, 1, 32'd1);
		send_word(2147483647, 2147483647, 32'd4);
		in_valid <= 1'b0;
		@(posedge clk);
		// hold off until every result is back
		drain();

		random_words(12);
		set_curve(101, 1'b0);
		random_words(16);
		set_curve(5, 1'b0);
		random_words(16);
		quiet = 1'b1;
		set_curve(3, 1'b0);
		random_words(16);
		quiet = 1'b0;
		set_curve(0, 1'b0);
		random_words(12);
		set_curve(91, 1'b0);
		random_words(16);
		set_curve(2147483629, 1'b0);
		random_words(16);
		// base point with y = 0: doubling yields infinity
		set_curve(65521, 1'b1);
		send_word(base_x, 0, 32'd2);
		random_words(14);
		set_curve(2147483647, 1'b0);
		write_reg(CFG_CURVE_A, 0);
		write_reg(CFG_CURVE_B, 0);
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_a  = 0;
		base_x = 0;
		base_y = 0;
		random_words(10);

		repeat (2000) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
